>>> sv/mdm_pkg.sv
// Shared types and constants for the mecanum drive mixer.
package mdm_pkg;

  localparam int AxisW   = 8;
  localparam int CfgW    = 7;
  localparam int CfgIdxW = 2;
  localparam int DrvW    = 10;
  localparam int MagW    = 9;
  localparam int NumW    = 16;
  localparam int QuoW    = 7;
  localparam int Lanes   = 4;

  localparam int LaneLf = 0;
  localparam int LaneLb = 1;
  localparam int LaneRf = 2;
  localparam int LaneRb = 3;

  localparam logic [CfgIdxW-1:0] CfgDeadband  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTurnSpeed = 2'd1;

  localparam logic [CfgW-1:0] DeadbandRst  = 7'd10;
  localparam logic [CfgW-1:0] TurnSpeedRst = 7'd64;

  localparam logic [MagW-1:0] AxisLimit = 9'd127;

  typedef struct packed {
    logic [Lanes-1:0][NumW-1:0]  num;
    logic [MagW-1:0]             peak;
    logic [Lanes-1:0]            neg;
    logic                        scale;
    logic [Lanes-1:0][AxisW-1:0] raw;
  } div_req_t;

  typedef struct packed {
    logic [Lanes-1:0][QuoW-1:0]  quo;
    logic [Lanes-1:0]            neg;
    logic                        scale;
    logic [Lanes-1:0][AxisW-1:0] raw;
  } div_rsp_t;

endpackage

>>> sv/mecanum_drive_mixer.sv
// Mecanum drive mixer: deadband, turn selection, four-wheel mix and normalization.
// One joystick request enters per cycle unless the pipeline stalls; its four wheel drives leave after these stages:
// one stage for deadband and mixing, one for the peak search and the 127*|drive| product,
// seven for the restoring divider (one quotient bit per stage, all four wheels in parallel)
// and the output register. Stalls on the output back up stage by stage; bubbles are filled.
// Register writes (index 0 deadband, index 1 turn speed, others ignored) are always taken.
module mecanum_drive_mixer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [mdm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [mdm_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [mdm_pkg::AxisW-1:0]    forward_axis_i,
  input  logic signed [mdm_pkg::AxisW-1:0]    strafe_axis_i,
  input  logic                                turn_right_button_i,
  input  logic                                turn_left_button_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mdm_pkg::AxisW-1:0]    left_front_drive_o,
  output logic signed [mdm_pkg::AxisW-1:0]    left_back_drive_o,
  output logic signed [mdm_pkg::AxisW-1:0]    right_front_drive_o,
  output logic signed [mdm_pkg::AxisW-1:0]    right_back_drive_o
);
  import mdm_pkg::*;

  logic [CfgW-1:0] deadband_q, turn_speed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q   <= DeadbandRst;
      turn_speed_q <= TurnSpeedRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDeadband:  deadband_q   <= cfg_data_i;
        CfgTurnSpeed: turn_speed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic              en1, en2, en3;
  logic              v1_q, v2_q, v3_q;
  logic              div_ready, div_valid;
  div_req_t          req_d, req_q;
  div_rsp_t          rsp;
  logic signed [DrvW-1:0] drv_d [Lanes];
  logic signed [DrvW-1:0] drv_q [Lanes];
  logic signed [AxisW-1:0] out_d [Lanes];
  logic signed [AxisW-1:0] out_q [Lanes];

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || div_ready;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // stage 1: deadband, turn, mix
  always_comb begin
    logic [AxisW-1:0]        fmag, smag;
    logic signed [AxisW-1:0] fwd, str, trn;
    logic signed [DrvW-1:0]  f, s, t;
    fmag = forward_axis_i[AxisW-1] ? (~forward_axis_i + 1'b1) : forward_axis_i;
    smag = strafe_axis_i[AxisW-1] ? (~strafe_axis_i + 1'b1) : strafe_axis_i;
    fwd  = (fmag > AxisW'(deadband_q)) ? forward_axis_i : '0;
    str  = (smag > AxisW'(deadband_q)) ? strafe_axis_i : '0;
    if (turn_right_button_i) begin
      trn = AxisW'(turn_speed_q);
    end else if (turn_left_button_i) begin
      trn = -AxisW'(turn_speed_q);
    end else begin
      trn = '0;
    end
    f = DrvW'(fwd);
    s = DrvW'(str);
    t = DrvW'(trn);
    drv_d[LaneLf] = f + t + s;
    drv_d[LaneLb] = f + t - s;
    drv_d[LaneRf] = f - t - s;
    drv_d[LaneRb] = f - t + s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      drv_q <= drv_d;
    end
  end

  // stage 2: magnitudes, peak, 127*|drive|
  always_comb begin
    logic [DrvW-1:0] am;
    logic [MagW-1:0] m [Lanes];
    logic [MagW-1:0] pk;
    pk = '0;
    for (int l = 0; l < Lanes; l++) begin
      am   = drv_q[l][DrvW-1] ? (~drv_q[l] + 1'b1) : drv_q[l];
      m[l] = am[MagW-1:0];
      if (m[l] > pk) begin
        pk = m[l];
      end
    end
    for (int l = 0; l < Lanes; l++) begin
      req_d.num[l] = (NumW'(m[l]) << QuoW) - NumW'(m[l]);
      req_d.neg[l] = drv_q[l][DrvW-1];
      req_d.raw[l] = drv_q[l][AxisW-1:0];
    end
    req_d.peak  = pk;
    req_d.scale = pk > AxisLimit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      req_q <= req_d;
    end
  end

  mdm_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (v2_q),
    .req_ready_o (div_ready),
    .req_i       (req_q),
    .rsp_valid_o (div_valid),
    .rsp_ready_i (en3),
    .rsp_o       (rsp)
  );

  // output: restore sign or pass the unscaled drive
  always_comb begin
    logic [AxisW-1:0] q8;
    for (int l = 0; l < Lanes; l++) begin
      q8 = {1'b0, rsp.quo[l]};
      if (rsp.scale) begin
        out_d[l] = rsp.neg[l] ? (~q8 + 1'b1) : q8;
      end else begin
        out_d[l] = rsp.raw[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && div_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o         = v3_q;
  assign left_front_drive_o  = out_q[LaneLf];
  assign left_back_drive_o   = out_q[LaneLb];
  assign right_front_drive_o = out_q[LaneRf];
  assign right_back_drive_o  = out_q[LaneRb];

`ifndef SYNTHESIS
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_front_drive_o != 8'sh80 && left_back_drive_o != 8'sh80 &&
                     right_front_drive_o != 8'sh80 && right_back_drive_o != 8'sh80))
    else $error("drive outside -127..127");

  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output register");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !div_ready) |=> v2_q && $stable(req_q))
    else $error("peak stage lost a request during divider stall");
`endif

endmodule

>>> sv/mdm_div.sv
// Pipelined restoring divider, four lanes, one quotient bit per stage.
module mdm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  mdm_pkg::div_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output mdm_pkg::div_rsp_t rsp_o
);
  import mdm_pkg::*;

  localparam int Steps = QuoW;

  typedef struct packed {
    logic [Lanes-1:0][NumW-1:0]  rem;
    logic [Lanes-1:0][QuoW-1:0]  quo;
    logic [MagW-1:0]             peak;
    logic [Lanes-1:0]            neg;
    logic                        scale;
    logic [Lanes-1:0][AxisW-1:0] raw;
  } step_t;

  step_t            src  [Steps];
  step_t            st_q [Steps];
  logic [Steps-1:0] src_v;
  logic [Steps-1:0] v_q;
  logic [Steps:0]   en;

  always_comb begin
    en[Steps] = rsp_ready_i;
    for (int s = Steps - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign req_ready_o = en[0];

  assign src[0]   = '{rem: req_i.num, quo: '0, peak: req_i.peak, neg: req_i.neg,
                      scale: req_i.scale, raw: req_i.raw};
  assign src_v[0] = req_valid_i;

  for (genvar s = 1; s < Steps; s++) begin : g_link
    assign src[s]   = st_q[s-1];
    assign src_v[s] = v_q[s-1];
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam int Bit = QuoW - 1 - s;
    step_t      st_d;
    logic [NumW-1:0] sh;

    assign sh = NumW'(src[s].peak) << Bit;

    always_comb begin
      st_d = src[s];
      for (int l = 0; l < Lanes; l++) begin
        if (src[s].rem[l] >= sh) begin
          st_d.rem[l]      = src[s].rem[l] - sh;
          st_d.quo[l][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= src_v[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s] && src_v[s]) begin
        st_q[s] <= st_d;
      end
    end
  end

  assign rsp_valid_o  = v_q[Steps-1];
  assign rsp_o.quo    = st_q[Steps-1].quo;
  assign rsp_o.neg    = st_q[Steps-1].neg;
  assign rsp_o.scale  = st_q[Steps-1].scale;
  assign rsp_o.raw    = st_q[Steps-1].raw;

endmodule
